@@ rtl/ttg_pkg.sv @@
// ----------------------------------------------------------------------------
// ttg_pkg
// Shared types and constants of the touch tap gesture classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ttg_pkg;

    localparam int DEF_INTENSITY_STEPS = 10;
    localparam int DEF_MAX_INTENSITY   = 100;
    localparam int DEF_COORD_BITS      = 12;

    localparam int KIND_W      = 3;
    localparam int GESTURE_W   = 2;
    localparam int INTENSITY_W = 7;
    localparam int THR_W       = 8;
    localparam int MS_W        = 14;
    localparam int CNT_W       = 16;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 14;

    typedef enum logic [KIND_W-1:0] {
        KIND_PRESS   = 3'd0,
        KIND_DRAG    = 3'd1,
        KIND_RELEASE = 3'd2,
        KIND_CANCEL  = 3'd3,
        KIND_TICK    = 3'd4
    } t_kind;

    typedef enum logic [GESTURE_W-1:0] {
        GEST_NONE       = 2'd0,
        GEST_TAP        = 2'd1,
        GEST_DOUBLE_TAP = 2'd2,
        GEST_LONG_TAP   = 2'd3
    } t_gesture;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TAP_THR      = 3'd0,
        CFG_DRAG_THR     = 3'd1,
        CFG_DTAP_MAX     = 3'd2,
        CFG_LTAP_THR     = 3'd3,
        CFG_LTAP_DELAY   = 3'd4
    } t_cfg_addr;

    typedef struct packed {
        logic [THR_W-1:0] tap_threshold;
        logic [THR_W-1:0] drag_threshold;
        logic [MS_W-1:0]  double_tap_max_ms;
        logic [MS_W-1:0]  long_tap_threshold_ms;
        logic [MS_W-1:0]  long_tap_initial_delay_ms;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/ttg_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ttg_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ttg_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ttg_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [ttg_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output ttg_pkg::t_cfg                      o_cfg
);
    import ttg_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tap_threshold             <= THR_W'(4);
            r_cfg.drag_threshold            <= THR_W'(20);
            r_cfg.double_tap_max_ms         <= MS_W'(400);
            r_cfg.long_tap_threshold_ms     <= MS_W'(800);
            r_cfg.long_tap_initial_delay_ms <= MS_W'(200);
        end else if (i_cfg_we) begin
            case (t_cfg_addr'(i_cfg_addr))
                CFG_TAP_THR:    r_cfg.tap_threshold             <= i_cfg_wdata[THR_W-1:0];
                CFG_DRAG_THR:   r_cfg.drag_threshold            <= i_cfg_wdata[THR_W-1:0];
                CFG_DTAP_MAX:   r_cfg.double_tap_max_ms         <= i_cfg_wdata[MS_W-1:0];
                CFG_LTAP_THR:   r_cfg.long_tap_threshold_ms     <= i_cfg_wdata[MS_W-1:0];
                CFG_LTAP_DELAY: r_cfg.long_tap_initial_delay_ms <= i_cfg_wdata[MS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/ttg_core.sv @@
// ----------------------------------------------------------------------------
// ttg_core
// Gesture state and single-pass next-state / result logic for one event.
// ----------------------------------------------------------------------------
`default_nettype none

module ttg_core #(
    parameter int INTENSITY_STEPS = ttg_pkg::DEF_INTENSITY_STEPS,
    parameter int MAX_INTENSITY   = ttg_pkg::DEF_MAX_INTENSITY,
    parameter int COORD_BITS      = ttg_pkg::DEF_COORD_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ttg_pkg::t_cfg                   i_cfg,
    input  wire logic                            i_adv,
    input  wire logic [ttg_pkg::KIND_W-1:0]      i_kind,
    input  wire logic [COORD_BITS-1:0]           i_pos_x,
    input  wire logic [COORD_BITS-1:0]           i_pos_y,
    output logic [ttg_pkg::GESTURE_W-1:0]        o_gesture,
    output logic [COORD_BITS-1:0]                o_gesture_x,
    output logic [COORD_BITS-1:0]                o_gesture_y,
    output logic [ttg_pkg::INTENSITY_W-1:0]      o_intensity
);
    import ttg_pkg::*;

    localparam int STEP     = MAX_INTENSITY / INTENSITY_STEPS;
    localparam int SUM_W    = INTENSITY_W + 1;
    localparam int PROD_W   = CNT_W + 8;
    localparam logic [SUM_W-1:0] STEP_S  = SUM_W'(STEP);
    localparam logic [SUM_W-1:0] STEP2_S = SUM_W'(2 * STEP);
    localparam logic [SUM_W-1:0] MAX_S   = SUM_W'(MAX_INTENSITY);

    logic                   r_active, n_active;
    logic [COORD_BITS-1:0]  r_press_x, n_press_x;
    logic [COORD_BITS-1:0]  r_press_y, n_press_y;
    logic                   r_pending, n_pending;
    logic [COORD_BITS-1:0]  r_first_x, n_first_x;
    logic [COORD_BITS-1:0]  r_first_y, n_first_y;
    logic [CNT_W-1:0]       r_since, n_since;
    logic [CNT_W-1:0]       r_hold, n_hold;
    logic [INTENSITY_W-1:0] r_level, n_level;

    logic [COORD_BITS-1:0]  w_dpx, w_dpy, w_dfx, w_dfy;
    logic [COORD_BITS-1:0]  w_tap_thr, w_drag_thr;
    logic [CNT_W-1:0]       w_hold_inc;
    logic [MS_W-1:0]        w_span;
    logic [PROD_W-1:0]      w_prod;
    logic [SUM_W-1:0]       w_sum;
    logic                   w_fired;

    function automatic logic [COORD_BITS-1:0] absdiff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign w_dpx      = absdiff(i_pos_x, r_press_x);
    assign w_dpy      = absdiff(i_pos_y, r_press_y);
    assign w_dfx      = absdiff(i_pos_x, r_first_x);
    assign w_dfy      = absdiff(i_pos_y, r_first_y);
    assign w_tap_thr  = COORD_BITS'(i_cfg.tap_threshold);
    assign w_drag_thr = COORD_BITS'(i_cfg.drag_threshold);
    assign w_hold_inc = r_hold + CNT_W'(1);
    assign w_span     = (i_cfg.long_tap_threshold_ms > i_cfg.long_tap_initial_delay_ms) ?
                        (i_cfg.long_tap_threshold_ms - i_cfg.long_tap_initial_delay_ms) :
                        MS_W'(0);
    // hold_inc >= max(1, span / steps)  <=>  span < (hold_inc + 1) * steps
    assign w_prod     = (PROD_W'(w_hold_inc) + PROD_W'(1)) * PROD_W'(INTENSITY_STEPS);
    assign w_sum      = SUM_W'(r_level) + STEP_S;

    always_comb begin
        n_active    = r_active;
        n_press_x   = r_press_x;
        n_press_y   = r_press_y;
        n_pending   = r_pending;
        n_first_x   = r_first_x;
        n_first_y   = r_first_y;
        n_since     = r_since;
        n_hold      = r_hold;
        n_level     = r_level;
        w_fired     = 1'b0;
        o_gesture   = GEST_NONE;
        o_gesture_x = '0;
        o_gesture_y = '0;

        case (t_kind'(i_kind))
            KIND_PRESS: begin
                n_active  = 1'b1;
                n_press_x = i_pos_x;
                n_press_y = i_pos_y;
                n_hold    = '0;
                n_level   = '0;
                if (r_pending && (w_dfx > w_drag_thr || w_dfy > w_drag_thr ||
                                  r_since > CNT_W'(i_cfg.double_tap_max_ms))) begin
                    n_pending = 1'b0;
                end
            end
            KIND_DRAG: begin
                if (r_active && (w_dpx > w_tap_thr || w_dpy > w_tap_thr)) begin
                    n_active  = 1'b0;
                    n_hold    = '0;
                    n_level   = '0;
                    n_pending = 1'b0;
                end
            end
            KIND_RELEASE: begin
                if (r_active) begin
                    n_active = 1'b0;
                    n_hold   = '0;
                    n_level  = '0;
                    if (r_pending) begin
                        n_pending   = 1'b0;
                        o_gesture   = GEST_DOUBLE_TAP;
                        o_gesture_x = r_first_x;
                        o_gesture_y = r_first_y;
                    end else begin
                        n_pending   = 1'b1;
                        n_first_x   = r_press_x;
                        n_first_y   = r_press_y;
                        n_since     = '0;
                        o_gesture   = GEST_TAP;
                        o_gesture_x = r_press_x;
                        o_gesture_y = r_press_y;
                    end
                end
            end
            KIND_CANCEL: begin
                n_active  = 1'b0;
                n_hold    = '0;
                n_level   = '0;
                n_pending = 1'b0;
            end
            KIND_TICK: begin
                if (r_since != {CNT_W{1'b1}}) begin
                    n_since = r_since + CNT_W'(1);
                end
                if (r_active) begin
                    n_hold = w_hold_inc;
                    if (r_level == '0) begin
                        if (w_hold_inc >= CNT_W'(i_cfg.long_tap_initial_delay_ms)) begin
                            n_hold = '0;
                            if (STEP_S >= MAX_S || STEP2_S >= MAX_S) begin
                                w_fired = 1'b1;
                            end else begin
                                n_level = STEP2_S[INTENSITY_W-1:0];
                            end
                        end
                    end else if (PROD_W'(w_span) < w_prod) begin
                        n_hold = '0;
                        if (w_sum >= MAX_S) begin
                            w_fired = 1'b1;
                        end else begin
                            n_level = w_sum[INTENSITY_W-1:0];
                        end
                    end
                    if (w_fired) begin
                        o_gesture   = GEST_LONG_TAP;
                        o_gesture_x = r_press_x;
                        o_gesture_y = r_press_y;
                    end
                end
            end
            default: ;
        endcase

        if (w_fired) begin
            n_active  = 1'b0;
            n_hold    = '0;
            n_level   = '0;
            n_pending = 1'b0;
        end
        o_intensity = w_fired ? INTENSITY_W'(MAX_INTENSITY) : n_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_press_x <= '0;
            r_press_y <= '0;
            r_pending <= 1'b0;
            r_first_x <= '0;
            r_first_y <= '0;
            r_since   <= '0;
            r_hold    <= '0;
            r_level   <= '0;
        end else if (i_adv) begin
            r_active  <= n_active;
            r_press_x <= n_press_x;
            r_press_y <= n_press_y;
            r_pending <= n_pending;
            r_first_x <= n_first_x;
            r_first_y <= n_first_y;
            r_since   <= n_since;
            r_hold    <= n_hold;
            r_level   <= n_level;
        end
    end

endmodule

`default_nettype wire

@@ rtl/touch_tap_gesture_classifier.sv @@
// ----------------------------------------------------------------------------
// touch_tap_gesture_classifier
// Classifies single-pointer touch events into tap, double tap and long tap.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the s_axis stream (tuser = event kind, tdata = x, y).
//   Every event produces exactly one result on the m_axis stream
//   (tuser = gesture code, tdata = x, y, long tap intensity).
//   Registers are written through i_cfg_we / i_cfg_addr / i_cfg_wdata while
//   no event is in flight.
//   An accepted event passes the input register, then the result register.
//   Throughput: one event per cycle while the receiver does not stall; the
//   only loop is the gesture state register, updated from one event.
//   Reset (synchronous, active low) clears the gesture state, empties both
//   registers and loads the default thresholds.
//   When the receiver stalls, the result register holds its transfer, the
//   input register holds one more event and then s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_tap_gesture_classifier #(
    parameter int INTENSITY_STEPS = ttg_pkg::DEF_INTENSITY_STEPS,
    parameter int MAX_INTENSITY   = ttg_pkg::DEF_MAX_INTENSITY,
    parameter int COORD_BITS      = ttg_pkg::DEF_COORD_BITS,
    localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + ttg_pkg::INTENSITY_W + 7) / 8) * 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [IN_W-1:0]                  s_axis_tdata,  // pos_x, pos_y
    input  wire logic [ttg_pkg::KIND_W-1:0]       s_axis_tuser,  // kind
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [OUT_W-1:0]                      m_axis_tdata,  // gesture_x, gesture_y, intensity
    output logic [ttg_pkg::GESTURE_W-1:0]         m_axis_tuser,  // gesture
    input  wire logic                             i_cfg_we,
    input  wire logic [ttg_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [ttg_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import ttg_pkg::*;

    t_cfg w_cfg;

    logic                   r_in_valid;
    logic [KIND_W-1:0]      r_in_kind;
    logic [COORD_BITS-1:0]  r_in_x;
    logic [COORD_BITS-1:0]  r_in_y;

    logic                   r_out_valid;
    logic [GESTURE_W-1:0]   r_out_gesture;
    logic [COORD_BITS-1:0]  r_out_x;
    logic [COORD_BITS-1:0]  r_out_y;
    logic [INTENSITY_W-1:0] r_out_level;

    logic                   w_adv;
    logic [GESTURE_W-1:0]   w_gesture;
    logic [COORD_BITS-1:0]  w_gx;
    logic [COORD_BITS-1:0]  w_gy;
    logic [INTENSITY_W-1:0] w_level;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    ttg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    ttg_core #(
        .INTENSITY_STEPS (INTENSITY_STEPS),
        .MAX_INTENSITY   (MAX_INTENSITY),
        .COORD_BITS      (COORD_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_adv       (w_adv),
        .i_kind      (r_in_kind),
        .i_pos_x     (r_in_x),
        .i_pos_y     (r_in_y),
        .o_gesture   (w_gesture),
        .o_gesture_x (w_gx),
        .o_gesture_y (w_gy),
        .o_intensity (w_level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind <= s_axis_tuser;
            r_in_x    <= s_axis_tdata[COORD_BITS-1:0];
            r_in_y    <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_gesture <= w_gesture;
            r_out_x       <= w_gx;
            r_out_y       <= w_gy;
            r_out_level   <= w_level;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_gesture;
    assign m_axis_tdata  = OUT_W'({r_out_level, r_out_y, r_out_x});

endmodule

`default_nettype wire

@@ tb/tap_gesture_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tap_gesture_checker
// Watches the event and gesture streams of the tap classifier, tracks the
// register writes, predicts the gesture for every accepted event and compares
// each returned gesture field by field, oldest prediction first.
// ----------------------------------------------------------------------------

module tap_gesture_checker #(
    parameter int INTENSITY_STEPS = ttg_pkg::DEF_INTENSITY_STEPS,
    parameter int MAX_INTENSITY   = ttg_pkg::DEF_MAX_INTENSITY,
    parameter int IN_W            = 24,
    parameter int OUT_W           = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [IN_W-1:0]                s_axis_tdata,  // pos_x, pos_y
    input  logic [ttg_pkg::KIND_W-1:0]     s_axis_tuser,  // kind
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [OUT_W-1:0]               m_axis_tdata,  // gesture_x, gesture_y, intensity
    input  logic [ttg_pkg::GESTURE_W-1:0]  m_axis_tuser,  // gesture
    input  logic                           i_cfg_we,
    input  logic [ttg_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ttg_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_result_count,
    output int                             o_tap_count,
    output int                             o_double_count,
    output int                             o_long_count
);
    import ttg_pkg::*;

    localparam int RISE = MAX_INTENSITY / INTENSITY_STEPS;

    typedef struct {
        logic [GESTURE_W-1:0]   gesture;
        logic [11:0]            x;
        logic [11:0]            y;
        logic [INTENSITY_W-1:0] intensity;
    } t_gesture_result;

    t_gesture_result gesture_q[$];

    // register copies
    logic [THR_W-1:0] tap_thr;
    logic [THR_W-1:0] drag_thr;
    logic [MS_W-1:0]  dtap_max;
    logic [MS_W-1:0]  ltap_thr;
    logic [MS_W-1:0]  ltap_delay;

    // gesture state
    bit          held;
    logic [11:0] down_x;
    logic [11:0] down_y;
    bit          tap_waiting;
    logic [11:0] tap_x;
    logic [11:0] tap_y;
    logic [15:0] since_tap;
    int          hold_cnt;
    int          level;

    int mismatches;
    int results;
    int taps;
    int doubles;
    int longs;

    function automatic int axis_dist(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int rise_period();
        int p;
        p = 0;
        if (ltap_thr > ltap_delay)
            p = (int'(ltap_thr) - int'(ltap_delay)) / INTENSITY_STEPS;
        return (p < 1) ? 1 : p;
    endfunction

    task automatic drop_touch(input bit drop_tap);
        held = 1'b0;
        hold_cnt = 0;
        level = 0;
        if (drop_tap)
            tap_waiting = 1'b0;
    endtask

    task automatic classify(input logic [KIND_W-1:0] kind, input logic [11:0] px,
                            input logic [11:0] py, output t_gesture_result r);
        bit fired;
        fired = 1'b0;
        r.gesture = GEST_NONE;
        r.x = '0;
        r.y = '0;
        r.intensity = '0;
        case (kind)
            KIND_PRESS: begin
                held = 1'b1;
                down_x = px;
                down_y = py;
                hold_cnt = 0;
                level = 0;
                if (tap_waiting) begin
                    if (axis_dist(px, tap_x) > drag_thr || axis_dist(py, tap_y) > drag_thr)
                        tap_waiting = 1'b0;
                    else if (since_tap > dtap_max)
                        tap_waiting = 1'b0;
                end
            end
            KIND_DRAG: begin
                if (held && (axis_dist(px, down_x) > tap_thr ||
                             axis_dist(py, down_y) > tap_thr))
                    drop_touch(1'b1);
            end
            KIND_RELEASE: begin
                if (held) begin
                    drop_touch(1'b0);
                    if (tap_waiting) begin
                        tap_waiting = 1'b0;
                        r.gesture = GEST_DOUBLE_TAP;
                        r.x = tap_x;
                        r.y = tap_y;
                    end else begin
                        tap_waiting = 1'b1;
                        tap_x = down_x;
                        tap_y = down_y;
                        since_tap = '0;
                        r.gesture = GEST_TAP;
                        r.x = down_x;
                        r.y = down_y;
                    end
                end
            end
            KIND_CANCEL: begin
                drop_touch(1'b1);
            end
            KIND_TICK: begin
                if (since_tap != 16'hFFFF)
                    since_tap++;
                if (held) begin
                    hold_cnt++;
                    if (level == 0) begin
                        // first rise fires twice: the restarted timer expires at once
                        if (hold_cnt >= ltap_delay) begin
                            hold_cnt = 0;
                            level += RISE;
                            fired = (level >= MAX_INTENSITY);
                            if (!fired) begin
                                level += RISE;
                                fired = (level >= MAX_INTENSITY);
                            end
                        end
                    end else if (hold_cnt >= rise_period()) begin
                        hold_cnt = 0;
                        level += RISE;
                        fired = (level >= MAX_INTENSITY);
                    end
                    if (fired) begin
                        r.gesture = GEST_LONG_TAP;
                        r.x = down_x;
                        r.y = down_y;
                    end
                end
            end
            default: ;
        endcase
        if (fired) begin
            r.intensity = INTENSITY_W'(MAX_INTENSITY);
            drop_touch(1'b1);
        end else begin
            r.intensity = INTENSITY_W'(level);
        end
    endtask

    task automatic report_field(input string name, input int want_v, input int got_v);
        mismatches++;
        if (mismatches <= 30)
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
    endtask

    always @(posedge i_clk) begin : monitor
        t_gesture_result want;
        t_gesture_result got;
        if (!i_rst_n) begin
            tap_thr = 8'd4;
            drag_thr = 8'd20;
            dtap_max = 14'd400;
            ltap_thr = 14'd800;
            ltap_delay = 14'd200;
            held = 1'b0;
            down_x = '0;
            down_y = '0;
            tap_waiting = 1'b0;
            tap_x = '0;
            tap_y = '0;
            since_tap = '0;
            hold_cnt = 0;
            level = 0;
            gesture_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.gesture = m_axis_tuser;
                got.x = m_axis_tdata[11:0];
                got.y = m_axis_tdata[23:12];
                got.intensity = m_axis_tdata[24 +: INTENSITY_W];
                results++;
                if (gesture_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 30)
                        $display("%0t: unexpected transfer, expected none, actual %0d/%0d/%0d/%0d",
                                 $time, got.gesture, got.x, got.y, got.intensity);
                end else begin
                    want = gesture_q.pop_front();
                    if (got.gesture !== want.gesture)
                        report_field("gesture", want.gesture, got.gesture);
                    if (got.x !== want.x)
                        report_field("gesture_x", want.x, got.x);
                    if (got.y !== want.y)
                        report_field("gesture_y", want.y, got.y);
                    if (got.intensity !== want.intensity)
                        report_field("intensity", want.intensity, got.intensity);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                classify(s_axis_tuser, s_axis_tdata[11:0], s_axis_tdata[23:12], want);
                case (want.gesture)
                    GEST_TAP:        taps++;
                    GEST_DOUBLE_TAP: doubles++;
                    GEST_LONG_TAP:   longs++;
                    default: ;
                endcase
                gesture_q.push_back(want);
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_TAP_THR:    tap_thr = i_cfg_wdata[THR_W-1:0];
                    CFG_DRAG_THR:   drag_thr = i_cfg_wdata[THR_W-1:0];
                    CFG_DTAP_MAX:   dtap_max = i_cfg_wdata[MS_W-1:0];
                    CFG_LTAP_THR:   ltap_thr = i_cfg_wdata[MS_W-1:0];
                    CFG_LTAP_DELAY: ltap_delay = i_cfg_wdata[MS_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatches;
        o_pending <= gesture_q.size();
        o_result_count <= results;
        o_tap_count <= taps;
        o_double_count <= doubles;
        o_long_count <= longs;
    end

endmodule

@@ tb/tb_touch_tap_gesture_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_tap_gesture_classifier
// Drives touch events into the tap classifier: a directed pass over taps,
// double taps, cancels and ignored events, then well-formed random gesture
// sequences mixed with noise under several register settings, with bursty
// input, a stalling receiver and long receiver hold-offs. The checker
// instance predicts and compares; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------

module tb_touch_tap_gesture_classifier;

    import ttg_pkg::*;

    localparam int IN_W         = ((2 * DEF_COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W        = ((2 * DEF_COORD_BITS + INTENSITY_W + 7) / 8) * 8;
    localparam int LONG_STALL   = 300;
    localparam int WATCHDOG     = 2000;
    localparam int PHASE_EVENTS = 140;
    localparam int COORD_MAX    = 4095;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    wire                   s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata = '0;   // pos_x, pos_y
    logic [KIND_W-1:0]     s_axis_tuser = '0;   // kind
    wire                   m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    wire  [OUT_W-1:0]      m_axis_tdata;        // gesture_x, gesture_y, intensity
    wire  [GESTURE_W-1:0]  m_axis_tuser;        // gesture
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    int chk_fails;
    int chk_pending;
    int chk_results;
    int chk_taps;
    int chk_doubles;
    int chk_longs;

    int  events_sent = 0;
    int  burst_left = 0;
    bit  steady_send = 1'b0;
    bit  long_stall_req = 1'b0;
    int  settings_run = 1;
    int  quiet = 0;
    int  cur_tap = 4;
    int  cur_drag = 20;
    int  cur_dtap = 400;

    touch_tap_gesture_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    tap_gesture_checker #(
        .IN_W  (IN_W),
        .OUT_W (OUT_W)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_fail_count   (chk_fails),
        .o_pending      (chk_pending),
        .o_result_count (chk_results),
        .o_tap_count    (chk_taps),
        .o_double_count (chk_doubles),
        .o_long_count   (chk_longs)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: changes its stall pattern after each span of random length
    initial begin : rx_pattern
        int mode;
        int span;
        int n;
        @(posedge i_clk);
        forever begin
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(16, 200);
                n = 0;
                while (n < span && !long_stall_req) begin
                    case (mode)
                        0:       m_axis_tready <= 1'b1;
                        1:       m_axis_tready <= 1'($urandom_range(0, 1));
                        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge i_clk);
                    n++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG);
            $display("touch_tap_gesture_classifier test failed");
            $finish;
        end
    end

    task automatic send_event(input logic [KIND_W-1:0] kind, input int x, input int y);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = steady_send ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= IN_W'({y[11:0], x[11:0]});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        if (kind <= KIND_TICK)
            events_sent++;
    endtask

    function automatic int rand_coord();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 0;
        if (r == 1)
            return COORD_MAX;
        return $urandom_range(0, COORD_MAX);
    endfunction

    // point within +/- spread of c, clamped to the screen
    function automatic int near(input int c, input int spread);
        int v;
        v = c + $urandom_range(0, 2 * spread) - spread;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v;
    endfunction

    task automatic send_ticks(input int n);
        repeat (n) send_event(KIND_TICK, rand_coord(), rand_coord());
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_addr addr, input int value);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= CFG_DATA_W'(value);
        @(posedge i_clk);
    endtask

    task automatic program_regs(input int tap, input int drag, input int dtap,
                                input int lthr, input int ldly);
        write_reg(CFG_TAP_THR, tap);
        write_reg(CFG_DRAG_THR, drag);
        write_reg(CFG_DTAP_MAX, dtap);
        write_reg(CFG_LTAP_THR, lthr);
        write_reg(CFG_LTAP_DELAY, ldly);
        i_cfg_we <= 1'b0;
        cur_tap = tap;
        cur_drag = drag;
        cur_dtap = dtap;
        settings_run++;
    endtask

    task automatic run_gestures(input int target);
        int start;
        int px;
        int py;
        int n;
        start = events_sent;
        while (events_sent - start < target) begin
            px = rand_coord();
            py = rand_coord();
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    send_event(KIND_PRESS, px, py);
                    repeat ($urandom_range(0, 2)) begin
                        if ($urandom_range(0, 1))
                            send_event(KIND_DRAG, near(px, cur_tap + 1), near(py, cur_tap + 1));
                        else
                            send_ticks($urandom_range(0, 3));
                    end
                    send_event(KIND_RELEASE, rand_coord(), rand_coord());
                    send_ticks($urandom_range(0, (cur_dtap + 2 < 40) ? cur_dtap + 2 : 40));
                end
                3, 4: begin
                    send_event(KIND_PRESS, px, py);
                    send_event(KIND_RELEASE, rand_coord(), rand_coord());
                    send_ticks($urandom_range(0, (cur_dtap + 2 < 40) ? cur_dtap + 2 : 40));
                    send_event(KIND_PRESS, near(px, cur_drag + 1), near(py, cur_drag + 1));
                    send_event(KIND_RELEASE, rand_coord(), rand_coord());
                end
                5: begin
                    send_event(KIND_PRESS, px, py);
                    n = $urandom_range(0, 120);
                    repeat (n) begin
                        if ($urandom_range(0, 15) == 0)
                            send_event(KIND_DRAG, near(px, cur_tap), near(py, cur_tap));
                        else
                            send_ticks(1);
                    end
                    send_event(KIND_RELEASE, rand_coord(), rand_coord());
                end
                6: begin
                    send_event(KIND_PRESS, px, py);
                    send_ticks($urandom_range(0, 3));
                    send_event(KIND_CANCEL, rand_coord(), rand_coord());
                    if ($urandom_range(0, 1))
                        send_event(KIND_RELEASE, rand_coord(), rand_coord());
                end
                7: begin
                    send_event(KIND_PRESS, px, py);
                    send_event(KIND_PRESS, rand_coord(), rand_coord());
                    send_event(KIND_RELEASE, rand_coord(), rand_coord());
                end
                default: begin
                    repeat ($urandom_range(1, 4))
                        send_event(KIND_W'($urandom_range(0, 7)), rand_coord(), rand_coord());
                end
            endcase
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pass at reset settings
        send_event(KIND_PRESS, 0, 0);
        send_event(KIND_RELEASE, 0, 0);
        send_event(KIND_PRESS, 20, 20);
        send_event(KIND_RELEASE, 0, 0);
        send_event(KIND_PRESS, COORD_MAX, COORD_MAX);
        send_event(KIND_DRAG, COORD_MAX - 4, COORD_MAX);
        send_event(KIND_DRAG, COORD_MAX, COORD_MAX - 5);
        send_event(KIND_RELEASE, 0, 0);
        send_event(KIND_DRAG, 7, 7);
        send_event(KIND_RELEASE, 0, 0);
        send_event(KIND_PRESS, 100, 200);
        send_event(KIND_RELEASE, 0, 0);
        send_event(KIND_PRESS, 121, 200);
        send_event(KIND_RELEASE, 0, 0);
        send_event(KIND_PRESS, 2730, 1365);
        send_event(KIND_PRESS, 1365, 2730);
        send_event(KIND_RELEASE, 0, 0);
        send_event(KIND_CANCEL, 0, 0);
        send_event(KIND_PRESS, 1365, 2730);
        send_event(KIND_RELEASE, 0, 0);
        send_event(KIND_TICK, COORD_MAX, COORD_MAX);
        send_event(KIND_TICK, 0, 0);
        send_event(KIND_PRESS, 1370, 2725);
        send_event(KIND_RELEASE, COORD_MAX, COORD_MAX);
        send_event(3'd5, COORD_MAX, 0);
        send_event(3'd6, 0, COORD_MAX);
        send_event(3'd7, 2730, 1365);
        wait_idle();

        steady_send = 1'b1;
        long_stall_req = 1'b1;
        run_gestures(PHASE_EVENTS);
        wait_idle();

        steady_send = 1'b0;
        program_regs(0, 0, 0, 0, 0);
        run_gestures(PHASE_EVENTS);
        wait_idle();

        program_regs(255, 255, 10000, 10000, 10000);
        run_gestures(PHASE_EVENTS);
        wait_idle();

        program_regs(8, 30, 50, 120, 20);
        long_stall_req = 1'b1;
        run_gestures(PHASE_EVENTS);
        wait_idle();

        // long tap threshold below the initial delay, so the step span is zero
        program_regs(2, 10, 25, 40, 60);
        run_gestures(PHASE_EVENTS);
        wait_idle();

        repeat (3) begin
            steady_send = ($urandom_range(0, 3) == 0);
            program_regs($urandom_range(0, 12), $urandom_range(0, 40), $urandom_range(0, 60),
                         $urandom_range(0, 140), $urandom_range(0, 30));
            run_gestures(PHASE_EVENTS);
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        $display("Sent %0d touch events under %0d register settings, checked %0d results",
                 events_sent, settings_run, chk_results);
        $display("Predicted %0d taps, %0d double taps, %0d long taps",
                 chk_taps, chk_doubles, chk_longs);
        if (chk_pending != 0)
            $display("%0t: %0d expected results never arrived", $time, chk_pending);
        if (chk_fails == 0 && chk_pending == 0)
            $display("touch_tap_gesture_classifier test passed");
        else
            $display("touch_tap_gesture_classifier test failed");
        $finish;
    end

endmodule

@@ touch_tap_gesture_classifier.f @@
rtl/ttg_pkg.sv
rtl/ttg_cfg_regs.sv
rtl/ttg_core.sv
rtl/touch_tap_gesture_classifier.sv
tb/tap_gesture_checker.sv
tb/tb_touch_tap_gesture_classifier.sv
